/* rtl/differential_drive_odometry_assert.svh */
// Assertion macros shared by the odometry RTL.
// Each expects clk_i and rst_ni in the scope where it is used.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH

// Same-cycle implication
`define DDO_ASSERT_IMPL(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication
`define DDO_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* rtl/ddo_pkg.sv */
package ddo_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned ATAN_LEN = 24;
  localparam int unsigned VW = 34;            // CORDIC vector width, Q2.30 plus headroom
  localparam int unsigned DIV_NW = 77;        // dividend width: 57-bit magnitude times 10^6
  localparam logic [19:0] US_PER_S = 20'd1000000;
  localparam logic signed [VW-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [31:0] MPT_RESET = 32'd1349461;
  localparam logic [23:0] HG_RESET = 24'd26076;
  localparam logic [7:0] REG_MPT = 8'd0;
  localparam logic [7:0] REG_HG = 8'd1;

  localparam logic [1:0] ST_PRIMED = 2'd0;
  localparam logic [1:0] ST_UPDATED = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_ZERO_DT = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_ML, S_MR, S_MH, S_CS, S_CW, S_MX, S_MY,
    S_DLS, S_DLW, S_DAS, S_DAW, S_DONE
  } state_e;

  typedef struct packed {
    logic        start;
    logic [31:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [VW-1:0] cos_v;
    logic signed [VW-1:0] sin_v;
  } cordic_rsp_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [31:0]       divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
  } div_rsp_t;

  // Arctangent of 2^-i as a 32-bit binary angle
  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;  5'd2: r = 32'd167458907;
      5'd3: r = 32'd85004756;   5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
      5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;    5'd8: r = 32'd2670163;
      5'd9: r = 32'd1335087;    5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;    5'd13: r = 32'd83443;     5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;     5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;      5'd19: r = 32'd1304;      5'd20: r = 32'd652;
      5'd21: r = 32'd326;       5'd22: r = 32'd163;       5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // Clamp a wide signed value to 32 bits signed
  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -68'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // Put the sign back on a rate magnitude and clamp
  function automatic logic [31:0] sat_rate(input logic [DIV_NW-1:0] q, input logic neg);
    logic        hi;
    logic [31:0] r;
    hi = |q[DIV_NW-1:32];
    if (neg) begin
      if (hi || (q[31] && (|q[30:0]))) r = 32'h8000_0000;
      else r = ~q[31:0] + 32'd1;
    end else begin
      if (hi || q[31]) r = 32'h7FFF_FFFF;
      else r = q[31:0];
    end
    return r;
  endfunction

endpackage

/* rtl/ddo_cordic.sv */
module ddo_cordic #(
  parameter int unsigned STEPS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ddo_pkg::cordic_req_t req_i,
  output ddo_pkg::cordic_rsp_t rsp_o
);
  import ddo_pkg::*;

  localparam int unsigned CW = $clog2(STEPS);

  logic signed [VW-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d, flip_q, flip_d;
  logic [31:0] a_plus, a_fold;
  logic signed [VW-1:0] xs, ys, at;

  always_comb begin
    a_plus = req_i.angle + 32'h4000_0000;
    a_fold = a_plus[31] ? (req_i.angle + 32'h8000_0000) : req_i.angle;
    xs = x_q >>> cnt_q;
    ys = y_q >>> cnt_q;
    at = VW'(atan_lut(5'(cnt_q)));
    x_d = x_q; y_d = y_q; z_d = z_q;
    cnt_d = cnt_q; busy_d = busy_q; flip_d = flip_q;
    done_d = 1'b0;
    if (req_i.start) begin
      // load folded angle and the unit vector scaled by the inverse gain
      flip_d = a_plus[31];
      z_d = {{(VW-32){a_fold[31]}}, a_fold};
      x_d = CORDIC_GAIN;
      y_d = '0;
      cnt_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // rotate toward zero residual angle
      if (!z_q[VW-1]) begin
        x_d = x_q - ys; y_d = y_q + xs; z_d = z_q - at;
      end else begin
        x_d = x_q + ys; y_d = y_q - xs; z_d = z_q + at;
      end
      if (cnt_q == CW'(STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
    flip_q <= flip_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.cos_v = flip_q ? -x_q : x_q;
  assign rsp_o.sin_v = flip_q ? -y_q : y_q;

endmodule

/* rtl/ddo_div.sv */
module ddo_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ddo_pkg::div_req_t req_i,
  output ddo_pkg::div_rsp_t rsp_o
);
  import ddo_pkg::*;

  localparam int unsigned CW = $clog2(DIV_NW);

  logic [31:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [DIV_NW-1:0] num_q, num_d, quot_q, quot_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;
  logic ge;

  always_comb begin
    trial = {rem_q, num_q[DIV_NW-1]};
    ge = trial >= {1'b0, dvs_q};
    rem_d = rem_q; dvs_d = dvs_q; num_d = num_q; quot_d = quot_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    if (req_i.start) begin
      rem_d = '0;
      dvs_d = req_i.divisor;
      num_d = req_i.dividend;
      quot_d = '0;
      cnt_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // one restoring step per cycle, quotient bits from the top
      rem_d = ge ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
      quot_d = {quot_q[DIV_NW-2:0], ge};
      num_d = {num_q[DIV_NW-2:0], 1'b0};
      if (cnt_q == CW'(DIV_NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    num_q <= num_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

/* rtl/differential_drive_odometry.sv */
// Differential-drive odometry: one encoder sample in, one pose result out. A
// sample that only primes the state or is skipped (invalid read, zero elapsed
// time) goes straight to the done state. An updating sample makes five
// passes through the shared 34x34 multiplier, runs one CORDIC step per
// cycle, and runs two 77-bit restoring divisions at one quotient bit per
// cycle. The input is not ready while a sample is in work; a finished
// result is held in the output register until it is taken.
`include "differential_drive_odometry_assert.svh"

module differential_drive_odometry #(
  parameter int unsigned CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // left_count, right_count, timestamp_us
  input  logic         s_axis_tuser,   // counts_valid
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [143:0] m_axis_tdata,   // pos_x, pos_y, heading, linear_velocity,
                                       // angular_velocity
  output logic [1:0]   m_axis_tuser,   // status
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);
  import ddo_pkg::*;

  state_e state_q, state_d;
  logic primed_q, out_valid_q;
  logic [31:0] mpt_q;
  logic [23:0] hg_q;
  logic [31:0] prev_l_q, prev_r_q, prev_t_q, x_acc_q, y_acc_q;
  logic [15:0] hd_q;
  logic [31:0] left_q, right_q, ts_q, dt_q;
  logic signed [31:0] dl_q, dr_q, dd_q;
  logic signed [57:0] dth_q;
  logic signed [VW-1:0] cos_q, sin_q;
  logic [31:0] lin_q, ang_q;
  logic [1:0] status_q;
  logic [143:0] out_data_q;
  logic [1:0] out_user_q;

  logic accept;
  logic signed [VW-1:0] mul_a, mul_b;
  logic signed [67:0] mul_p;
  logic [31:0] d_left, d_right, in_dt;
  logic signed [32:0] dsum;
  logic signed [57:0] dth_rnd;
  logic [31:0] dd_mag;
  logic [56:0] dth_mag;
  cordic_req_t c_req;
  cordic_rsp_t c_rsp;
  div_req_t d_req;
  div_rsp_t d_rsp;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_dt = s_axis_tdata[95:64] - prev_t_q;
  assign d_left = left_q - prev_l_q;
  assign d_right = right_q - prev_r_q;
  assign dsum = {dl_q[31], dl_q} + {dr_q[31], dr_q};
  assign dth_rnd = dth_q + 58'sd32768;
  assign dd_mag = dd_q[31] ? (~dd_q + 32'd1) : dd_q;
  assign dth_mag = dth_q[57] ? 57'(~dth_q + 58'd1) : dth_q[56:0];

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_ML: begin
        mul_a = {{2{d_left[31]}}, d_left};
        mul_b = {2'b00, mpt_q};
      end
      S_MR: begin
        mul_a = {{2{d_right[31]}}, d_right};
        mul_b = {2'b00, mpt_q};
      end
      S_MH: begin
        mul_a = {{2{dr_q[31]}}, dr_q} - {{2{dl_q[31]}}, dl_q};
        mul_b = {10'd0, hg_q};
      end
      S_MX: begin
        mul_a = {{2{dd_q[31]}}, dd_q};
        mul_b = cos_q;
      end
      S_MY: begin
        mul_a = {{2{dd_q[31]}}, dd_q};
        mul_b = sin_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Sequencer: next state and unit requests
  always_comb begin
    state_d = state_q;
    c_req.start = 1'b0;
    c_req.angle = {hd_q, 16'd0} + dth_q[32:1];
    d_req.start = 1'b0;
    d_req.divisor = dt_q;
    d_req.dividend = (state_q == S_DAS) ? DIV_NW'(dth_mag) * DIV_NW'(US_PER_S)
                                        : DIV_NW'(dd_mag) * DIV_NW'(US_PER_S);
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (primed_q && (in_dt != 32'd0) && s_axis_tuser) state_d = S_ML;
          else state_d = S_DONE;
        end
      end
      S_ML: state_d = S_MR;
      S_MR: state_d = S_MH;
      S_MH: state_d = S_CS;
      S_CS: begin
        c_req.start = 1'b1;
        state_d = S_CW;
      end
      S_CW: if (c_rsp.done) state_d = S_MX;
      S_MX: state_d = S_MY;
      S_MY: state_d = S_DLS;
      S_DLS: begin
        d_req.start = 1'b1;
        state_d = S_DLW;
      end
      S_DLW: if (d_rsp.done) state_d = S_DAS;
      S_DAS: begin
        d_req.start = 1'b1;
        state_d = S_DAW;
      end
      S_DAW: if (d_rsp.done) state_d = S_DONE;
      S_DONE: if (!out_valid_q || m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      primed_q <= 1'b0;
      out_valid_q <= 1'b0;
      mpt_q <= MPT_RESET;
      hg_q <= HG_RESET;
      prev_l_q <= '0;
      prev_r_q <= '0;
      prev_t_q <= '0;
      x_acc_q <= '0;
      y_acc_q <= '0;
      hd_q <= '0;
    end else begin
      state_q <= state_d;
      // take configuration writes
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_MPT) mpt_q <= cfg_data_i;
        else if (cfg_index_i == REG_HG) hg_q <= cfg_data_i[23:0];
      end
      // prime on the first valid sample
      if (accept && !primed_q && s_axis_tuser) begin
        primed_q <= 1'b1;
        prev_l_q <= s_axis_tdata[31:0];
        prev_r_q <= s_axis_tdata[63:32];
        prev_t_q <= s_axis_tdata[95:64];
      end
      if (state_q == S_MX) x_acc_q <= x_acc_q + mul_p[61:30];
      if (state_q == S_MY) y_acc_q <= y_acc_q + mul_p[61:30];
      // commit heading and stored sample at the end of an update
      if ((state_q == S_DAW) && d_rsp.done) begin
        hd_q <= hd_q + dth_rnd[31:16];
        prev_l_q <= left_q;
        prev_r_q <= right_q;
        prev_t_q <= ts_q;
      end
      // hand the result to the output register
      if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
      if ((state_q == S_DONE) && (!out_valid_q || m_axis_tready)) out_valid_q <= 1'b1;
    end
  end

  // Working registers and output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      left_q <= s_axis_tdata[31:0];
      right_q <= s_axis_tdata[63:32];
      ts_q <= s_axis_tdata[95:64];
      dt_q <= in_dt;
      lin_q <= '0;
      ang_q <= '0;
      if (!primed_q) status_q <= s_axis_tuser ? ST_PRIMED : ST_INVALID;
      else if (in_dt == 32'd0) status_q <= ST_ZERO_DT;
      else if (!s_axis_tuser) status_q <= ST_INVALID;
      else status_q <= ST_UPDATED;
    end
    if (state_q == S_ML) dl_q <= sat32(mul_p >>> 16);
    if (state_q == S_MR) dr_q <= sat32(mul_p >>> 16);
    if (state_q == S_MH) begin
      dth_q <= mul_p[57:0];
      dd_q <= dsum[32:1];
    end
    if (c_rsp.done) begin
      cos_q <= c_rsp.cos_v;
      sin_q <= c_rsp.sin_v;
    end
    if ((state_q == S_DLW) && d_rsp.done) lin_q <= sat_rate(d_rsp.quot, dd_q[31]);
    if ((state_q == S_DAW) && d_rsp.done) ang_q <= sat_rate(d_rsp.quot >> 16, dth_q[57]);
    if ((state_q == S_DONE) && (!out_valid_q || m_axis_tready)) begin
      out_data_q <= {ang_q, lin_q, hd_q, y_acc_q, x_acc_q};
      out_user_q <= status_q;
    end
  end

  ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (c_req),
    .rsp_o (c_rsp)
  );

  ddo_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (d_req),
    .rsp_o (d_rsp)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = out_data_q;
  assign m_axis_tuser = out_user_q;

  `DDO_ASSERT_NEXT(a_busy_after_req, accept, !s_axis_tready, "input ready while busy")
  `DDO_ASSERT_IMPL(a_skip_no_rate, m_axis_tvalid && (m_axis_tuser != ST_UPDATED),
    (m_axis_tdata[111:80] == 32'd0) && (m_axis_tdata[143:112] == 32'd0), "skip with rate")
  `DDO_ASSERT_IMPL(a_out_from_done, $rose(out_valid_q), $past(state_q) == S_DONE,
    "result loaded outside done state")

endmodule
